FILE: src/ppsu_pkg.sv
// shared constants and types for the particle push and spring update unit
package ppsu_pkg;

    localparam int HAND_COUNT_DEF = 2;
    localparam int COORD_BITS_DEF = 24;
    localparam int QUEUE_DEPTH    = 8;

    localparam int FACTOR_W    = 16;
    localparam int RADIUS_W    = 23;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 23;
    localparam int VSUM_EXTRA  = 3;
    localparam int FRAC_SHIFT  = 15;
    localparam int USER_W      = 3;

    localparam int USER_OPCODE_BIT  = 0;
    localparam int USER_SELECT_BIT  = 1;
    localparam int USER_PRESENT_BIT = 2;

    localparam logic [FACTOR_W-1:0] DAMPING_RESET = 16'd3277;
    localparam logic [FACTOR_W-1:0] RETURN_RESET  = 16'd1638;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 23'd12800;
    localparam logic [RADIUS_W-1:0] RADIUS_MIN    = 23'd1280;
    localparam logic signed [15:0]  ROUND_BIAS    = 16'sd16384;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DAMPING = 2'd0,
        CFG_RETURN  = 2'd1,
        CFG_RADIUS  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_UPDATE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [FACTOR_W-1:0] damping;
        logic [FACTOR_W-1:0] rate;
        logic [RADIUS_W-1:0] radius;
    } cfg_t;

endpackage

FILE: src/particle_push_and_spring_update_unit.sv
// top level of the particle push and spring update unit
//
// Input channel s_*: one item per transfer. tuser bit 0 is the opcode (0 loads
// a hand slot, 1 updates a particle), bit 1 the hand slot, bit 2 hand present.
// tdata carries pos, vel and home xyz. A load writes the hand table and
// produces no result; an update produces one result on m_* carrying the new
// position and velocity xyz, saturated to the coordinate range.
// Configuration port cfg_*: index 0 damping, 1 return rate, 2 push radius;
// always ready; write it only while no update is in progress, which the
// block does not enforce. Throughput: one item per cycle while m_tready is high.
// Path from the input transfer to m_tvalid: three front stages (box test,
// squares, distance compare and velocity sum), one queue slot, three back
// stages (damping, integration, spring product) feeding the output register.
// Reset clears the hand table valid bits, the queue and all stage valids and
// loads the configuration defaults. When the receiver stalls the back end
// holds, the queue fills and s_tready drops once queue plus front stages
// reach the queue depth.
module particle_push_and_spring_update_unit #(
    parameter int HAND_COUNT = ppsu_pkg::HAND_COUNT_DEF,
    parameter int COORD_BITS = ppsu_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, home_x, home_y, home_z
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // opcode, hand_select, hand_present
    input  logic [ppsu_pkg::USER_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    output logic [((6*COORD_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppsu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ppsu_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ppsu_pkg::*;

    localparam int AW    = 3 * COORD_BITS + VSUM_EXTRA;
    localparam int QW    = 3 * AW;
    localparam int OUT_W = ((6*COORD_BITS+7)/8)*8;
    localparam int NW    = $clog2(QUEUE_DEPTH + 1);

    cfg_t cfg_reg;

    logic             s_accept;
    logic             push_valid;
    logic [QW-1:0]    push_data;
    logic [1:0]       inflight;
    logic             pop;
    logic [QW-1:0]    pop_data;
    logic             q_not_empty;
    logic [NW-1:0]    q_count;
    logic [NW:0]      credit_used;
    logic [6*COORD_BITS-1:0] out_data;

    assign cfg_ready   = 1'b1;
    assign credit_used = (NW+1)'(q_count) + (NW+1)'(inflight);
    assign s_tready    = credit_used < (NW+1)'(QUEUE_DEPTH);
    assign s_accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.damping <= DAMPING_RESET;
            cfg_reg.rate    <= RETURN_RESET;
            cfg_reg.radius  <= RADIUS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DAMPING: cfg_reg.damping <= cfg_data[FACTOR_W-1:0];
                CFG_RETURN:  cfg_reg.rate    <= cfg_data[FACTOR_W-1:0];
                CFG_RADIUS:  cfg_reg.radius  <= (cfg_data[RADIUS_W-1:0] < RADIUS_MIN) ?
                                                RADIUS_MIN : cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    ppsu_front #(
        .HAND_COUNT (HAND_COUNT),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (s_accept),
        .in_user    (s_tuser),
        .in_data    (s_tdata[9*COORD_BITS-1:0]),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .inflight   (inflight)
    );

    ppsu_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    ppsu_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_not_empty),
        .in_data   (pop_data),
        .cfg       (cfg_reg),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = OUT_W'(out_data);

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_used <= (NW+1)'(QUEUE_DEPTH))
        else $error("queue credit exceeded");
`endif

endmodule

FILE: src/ppsu_front.sv
// front end: hand table, distance test and velocity accumulation
module ppsu_front #(
    parameter int HAND_COUNT = ppsu_pkg::HAND_COUNT_DEF,
    parameter int COORD_BITS = ppsu_pkg::COORD_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_accept,
    input  logic [ppsu_pkg::USER_W-1:0] in_user,
    input  logic [9*COORD_BITS-1:0]  in_data,
    input  ppsu_pkg::cfg_t           cfg,
    output logic                     push_valid,
    output logic [3*(3*COORD_BITS+ppsu_pkg::VSUM_EXTRA)-1:0] push_data,
    output logic [1:0]               inflight
);
    import ppsu_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int CW  = (DW > RADIUS_W) ? DW : RADIUS_W;
    localparam int SQW = 2 * RADIUS_W;
    localparam int DSW = SQW + 2;
    localparam int VW  = CB + VSUM_EXTRA;
    localparam int AW  = 3 * CB + VSUM_EXTRA;

    logic signed [CB-1:0] in_pos [3];
    logic signed [CB-1:0] in_vel [3];
    logic signed [CB-1:0] in_home [3];
    logic                 is_update;

    logic [HAND_COUNT-1:0] hand_valid_reg;
    logic signed [CB-1:0]  hand_pos_reg [HAND_COUNT][3];
    logic signed [CB-1:0]  hand_vel_reg [HAND_COUNT][3];

    logic [HAND_COUNT-1:0] near_now;
    logic [RADIUS_W-1:0]   mag_now [HAND_COUNT][3];

    logic                  f1_v_reg;
    logic [HAND_COUNT-1:0] f1_near_reg;
    logic [RADIUS_W-1:0]   f1_mag_reg [HAND_COUNT][3];
    logic signed [CB-1:0]  f1_pos_reg [3];
    logic signed [CB-1:0]  f1_vel_reg [3];
    logic signed [CB-1:0]  f1_home_reg [3];
    logic signed [CB-1:0]  f1_hvel_reg [HAND_COUNT][3];

    logic                  f2_v_reg;
    logic [HAND_COUNT-1:0] f2_near_reg;
    logic [SQW-1:0]        f2_sq_reg [HAND_COUNT][3];
    logic [SQW-1:0]        f2_r2_reg;
    logic signed [CB-1:0]  f2_pos_reg [3];
    logic signed [CB-1:0]  f2_vel_reg [3];
    logic signed [CB-1:0]  f2_home_reg [3];
    logic signed [CB-1:0]  f2_hvel_reg [HAND_COUNT][3];

    logic                  f3_v_reg;
    logic [3*AW-1:0]       f3_data_reg;
    logic [3*AW-1:0]       f3_data_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_pos[k]  = signed'(in_data[k*CB +: CB]);
            in_vel[k]  = signed'(in_data[(3+k)*CB +: CB]);
            in_home[k] = signed'(in_data[(6+k)*CB +: CB]);
        end
    end

    assign is_update = (in_user[USER_OPCODE_BIT] == OP_UPDATE);

    // hand table writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hand_valid_reg <= '0;
        end else if (in_accept && !is_update) begin
            for (int h = 0; h < HAND_COUNT; h++) begin
                if (int'(in_user[USER_SELECT_BIT]) == h) begin
                    hand_valid_reg[h] <= in_user[USER_PRESENT_BIT];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && !is_update) begin
            for (int h = 0; h < HAND_COUNT; h++) begin
                if (int'(in_user[USER_SELECT_BIT]) == h) begin
                    for (int k = 0; k < 3; k++) begin
                        hand_pos_reg[h][k] <= in_pos[k];
                        hand_vel_reg[h][k] <= in_vel[k];
                    end
                end
            end
        end
    end

    // per-axis box test against the radius
    always_comb begin
        logic signed [DW-1:0] d;
        logic [DW-1:0]        absd;
        logic                 all_in;
        for (int h = 0; h < HAND_COUNT; h++) begin
            all_in = 1'b1;
            for (int k = 0; k < 3; k++) begin
                d    = DW'(in_pos[k]) - DW'(hand_pos_reg[h][k]);
                absd = d[DW-1] ? DW'(-d) : DW'(d);
                if (CW'(absd) >= CW'(cfg.radius)) begin
                    all_in = 1'b0;
                end
                mag_now[h][k] = RADIUS_W'(CW'(absd));
            end
            near_now[h] = hand_valid_reg[h] & all_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end else begin
            f1_v_reg <= in_accept && is_update;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f1_near_reg <= near_now;
        f1_mag_reg  <= mag_now;
        f1_pos_reg  <= in_pos;
        f1_vel_reg  <= in_vel;
        f1_home_reg <= in_home;
        f1_hvel_reg <= hand_vel_reg;

        for (int h = 0; h < HAND_COUNT; h++) begin
            for (int k = 0; k < 3; k++) begin
                f2_sq_reg[h][k] <= SQW'(f1_mag_reg[h][k]) * SQW'(f1_mag_reg[h][k]);
            end
        end
        f2_r2_reg   <= SQW'(cfg.radius) * SQW'(cfg.radius);
        f2_near_reg <= f1_near_reg;
        f2_pos_reg  <= f1_pos_reg;
        f2_vel_reg  <= f1_vel_reg;
        f2_home_reg <= f1_home_reg;
        f2_hvel_reg <= f1_hvel_reg;

        f3_data_reg <= f3_data_next;
    end

    // squared distance compare and velocity sum
    always_comb begin
        logic [DSW-1:0]       dist2;
        logic [HAND_COUNT-1:0] pushes;
        logic signed [VW-1:0] vsum;
        for (int h = 0; h < HAND_COUNT; h++) begin
            dist2 = DSW'(f2_sq_reg[h][0]) + DSW'(f2_sq_reg[h][1]) + DSW'(f2_sq_reg[h][2]);
            pushes[h] = f2_near_reg[h] && (dist2 < DSW'(f2_r2_reg));
        end
        for (int k = 0; k < 3; k++) begin
            vsum = VW'(f2_vel_reg[k]);
            for (int h = 0; h < HAND_COUNT; h++) begin
                if (pushes[h]) begin
                    vsum = vsum + VW'(f2_hvel_reg[h][k]);
                end
            end
            f3_data_next[k*AW +: AW] = {f2_home_reg[k], vsum, f2_pos_reg[k]};
        end
    end

    assign push_valid = f3_v_reg;
    assign push_data  = f3_data_reg;
    assign inflight   = 2'(f1_v_reg) + 2'(f2_v_reg) + 2'(f3_v_reg);

endmodule

FILE: src/ppsu_queue.sv
// short queue between front end and back end
module ppsu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ppsu_pkg::QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    head_reg;
    logic [PW-1:0]    tail_reg;
    logic [NW-1:0]    count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                tail_reg <= (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (pop) begin
                head_reg <= (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            count_reg <= count_reg + NW'(push) - NW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= push_data;
        end
    end

    assign pop_data  = mem[head_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < NW'(DEPTH)))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

FILE: src/ppsu_back.sv
// back end: damping, integration, return spring and output register
module ppsu_back #(
    parameter int COORD_BITS = ppsu_pkg::COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  logic [3*(3*COORD_BITS+ppsu_pkg::VSUM_EXTRA)-1:0] in_data,
    input  ppsu_pkg::cfg_t          cfg,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [6*COORD_BITS-1:0] out_data
);
    import ppsu_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int VW  = CB + VSUM_EXTRA;
    localparam int AW  = 3 * CB + VSUM_EXTRA;
    localparam int P1W = VW + FACTOR_W + 1;
    localparam int P2W = CB + 2 + FACTOR_W + 1;
    localparam int WW  = P1W;
    localparam logic signed [WW-1:0] SMAX = {{(WW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [WW-1:0] SMIN = {{(WW-CB+1){1'b1}}, {(CB-1){1'b0}}};

    function automatic logic signed [CB-1:0] sat_cb(input logic signed [WW-1:0] x);
        logic signed [CB-1:0] r;
        if (x > SMAX) begin
            r = SMAX[CB-1:0];
        end else if (x < SMIN) begin
            r = SMIN[CB-1:0];
        end else begin
            r = x[CB-1:0];
        end
        return r;
    endfunction

    logic adv;
    logic b1_v_reg, b2_v_reg, b3_v_reg, out_v_reg;

    logic signed [FACTOR_W:0] damp_s;
    logic signed [FACTOR_W:0] rate_s;

    logic signed [P1W-1:0] b1_prod_reg [3];
    logic signed [CB-1:0]  b1_pos_reg [3];
    logic signed [CB-1:0]  b1_home_reg [3];

    logic signed [CB-1:0]  b2_vel_reg [3];
    logic signed [CB:0]    b2_p1_reg [3];
    logic signed [CB-1:0]  b2_home_reg [3];

    logic signed [P2W-1:0] b3_prod_reg [3];
    logic signed [CB:0]    b3_p1_reg [3];
    logic signed [CB-1:0]  b3_vel_reg [3];

    logic [6*CB-1:0]       out_data_reg;
    logic [6*CB-1:0]       out_data_next;

    assign adv    = !out_v_reg || out_ready;
    assign pop    = in_valid && adv;
    assign damp_s = {1'b0, cfg.damping};
    assign rate_s = {1'b0, cfg.rate};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            b3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            b1_v_reg  <= pop;
            b2_v_reg  <= b1_v_reg;
            b3_v_reg  <= b2_v_reg;
            out_v_reg <= b3_v_reg;
        end
    end

    always_comb begin
        logic signed [WW-1:0]  rr;
        logic signed [WW-1:0]  p2;
        for (int k = 0; k < 3; k++) begin
            rr = (WW'(b3_prod_reg[k]) + WW'(ROUND_BIAS)) >>> FRAC_SHIFT;
            p2 = WW'(b3_p1_reg[k]) - rr;
            out_data_next[k*CB +: CB]     = sat_cb(p2);
            out_data_next[(3+k)*CB +: CB] = b3_vel_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [VW-1:0]   vsum;
        logic signed [WW-1:0]   rv;
        logic signed [CB-1:0]   vs;
        logic signed [CB+1:0]   diff;
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                vsum = signed'(in_data[k*AW + CB +: VW]);
                b1_prod_reg[k] <= P1W'(vsum) * P1W'(damp_s);
                b1_pos_reg[k]  <= signed'(in_data[k*AW +: CB]);
                b1_home_reg[k] <= signed'(in_data[k*AW + CB + VW +: CB]);

                rv = (WW'(b1_prod_reg[k]) + WW'(ROUND_BIAS)) >>> FRAC_SHIFT;
                vs = sat_cb(rv);
                b2_vel_reg[k]  <= vs;
                b2_p1_reg[k]   <= (CB+1)'(b1_pos_reg[k]) + (CB+1)'(vs);
                b2_home_reg[k] <= b1_home_reg[k];

                diff = (CB+2)'(b2_p1_reg[k]) - (CB+2)'(b2_home_reg[k]);
                b3_prod_reg[k] <= P2W'(diff) * P2W'(rate_s);
                b3_p1_reg[k]   <= b2_p1_reg[k];
                b3_vel_reg[k]  <= b2_vel_reg[k];
            end
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: bench/tb_top.sv
// testbench for the particle push and spring update unit: self-checking with a
// bit-true predictor, random idling on both channels and configuration sweeps
module tb_top;
    import ppsu_pkg::*;

    typedef logic [2:0][23:0] vec3_t;

    typedef struct packed {
        opcode_t op;
        logic    sel;
        logic    pres;
        vec3_t   pos;
        vec3_t   vel;
        vec3_t   home;
    } particle_item_t;

    typedef struct packed {
        vec3_t nvel;
        vec3_t npos;
    } motion_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [215:0]           s_tdata;
    logic [USER_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [143:0]           m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    motion_t motion_q[$];
    int      error_count = 0;
    bit      tx_quiet = 0;
    bit      rx_quiet = 0;
    int      rx_hold = 0;
    int      rx_wait = 0;

    // mirror of block state
    longint  damping_mirror;
    longint  rate_mirror;
    longint  radius_mirror;
    bit      hand_on[2];
    vec3_t   hand_pos[2];
    vec3_t   hand_vel[2];

    particle_push_and_spring_update_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint clamp24(longint x);
        if (x > 64'sd8388607) return 64'sd8388607;
        if (x < -64'sd8388608) return -64'sd8388608;
        return x;
    endfunction

    function automatic longint round_q15(longint x, longint f);
        return (x * f + 64'sd16384) >>> 15;
    endfunction

    function automatic bit update_motion(particle_item_t it, output motion_t r);
        longint radius, r2, dist2, vd, p;
        longint v[3];
        longint d[3];
        bit     near;
        r = '0;
        if (it.op == OP_LOAD) begin
            hand_on[it.sel] = it.pres;
            hand_pos[it.sel] = it.pos;
            hand_vel[it.sel] = it.vel;
            return 0;
        end
        radius = (radius_mirror < 1280) ? 64'sd1280 : radius_mirror;
        r2 = radius * radius;
        for (int k = 0; k < 3; k++) v[k] = longint'($signed(it.vel[k]));
        for (int h = 0; h < 2; h++) begin
            if (!hand_on[h]) continue;
            near = 1;
            dist2 = 0;
            for (int k = 0; k < 3; k++) begin
                d[k] = longint'($signed(it.pos[k])) - longint'($signed(hand_pos[h][k]));
                if (d[k] >= radius || -d[k] >= radius) near = 0;
                dist2 += d[k] * d[k];
            end
            if (near && dist2 < r2)
                for (int k = 0; k < 3; k++) v[k] += longint'($signed(hand_vel[h][k]));
        end
        for (int k = 0; k < 3; k++) begin
            vd = clamp24(round_q15(v[k], damping_mirror));
            p = longint'($signed(it.pos[k])) + vd;
            p -= round_q15(p - longint'($signed(it.home[k])), rate_mirror);
            r.npos[k] = 24'(clamp24(p));
            r.nvel[k] = 24'(vd);
        end
        return 1;
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        error_count++;
    endtask

    // result side: checks each transfer and draws its own stalls
    always @(posedge aclk) begin
        motion_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (motion_q.size() == 0) begin
                report_mismatch("unexpected result new_pos[0]", got.npos[0], '0);
            end else begin
                want = motion_q.pop_front();
                for (int k = 0; k < 3; k++) begin
                    if (got.npos[k] !== want.npos[k])
                        report_mismatch($sformatf("new_pos[%0d]", k), got.npos[k], want.npos[k]);
                    if (got.nvel[k] !== want.nvel[k])
                        report_mismatch($sformatf("new_vel[%0d]", k), got.nvel[k], want.nvel[k]);
                end
            end
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 7);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(particle_item_t it);
        int     gap;
        motion_t r;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {it.home, it.vel, it.pos};
        s_tuser <= {it.pres, it.sel, it.op};
        do @(posedge aclk); while (!s_tready);
        if (update_motion(it, r)) motion_q.insert(motion_q.size(), r);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (motion_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, longint val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DAMPING: damping_mirror = val & 16'hffff;
            CFG_RETURN:  rate_mirror = val & 16'hffff;
            default:     radius_mirror = val & 23'h7fffff;
        endcase
    endtask

    task automatic set_config(longint damp, longint rate, longint rad);
        drain();
        write_reg(CFG_DAMPING, damp);
        write_reg(CFG_RETURN, rate);
        write_reg(CFG_RADIUS, rad);
    endtask

    function automatic vec3_t mk3(int x, int y, int z);
        return {24'(z), 24'(y), 24'(x)};
    endfunction

    function automatic particle_item_t hand_load(bit sel, bit pres, vec3_t p, vec3_t v);
        particle_item_t it;
        it.op = OP_LOAD;
        it.sel = sel;
        it.pres = pres;
        it.pos = p;
        it.vel = v;
        it.home = any3();
        return it;
    endfunction

    function automatic particle_item_t particle(vec3_t p, vec3_t v, vec3_t h);
        particle_item_t it;
        it.op = OP_UPDATE;
        it.sel = 1'($urandom);
        it.pres = 1'($urandom);
        it.pos = p;
        it.vel = v;
        it.home = h;
        return it;
    endfunction

    function automatic vec3_t any3();
        return {24'($urandom), 24'($urandom), 24'($urandom)};
    endfunction

    function automatic vec3_t near3(vec3_t c, int span);
        vec3_t r;
        for (int k = 0; k < 3; k++)
            r[k] = c[k] + 24'($urandom_range(0, 2 * span) - span);
        return r;
    endfunction

    function automatic vec3_t small3(int span);
        return near3('0, span);
    endfunction

    task automatic test_directed;
        send_item(hand_load(0, 1, mk3(0, 0, 0), mk3(1000, -2000, 300)));
        send_item(hand_load(1, 0, mk3(0, 0, 0), mk3(5000, 5000, 5000)));
        send_item(particle(mk3(0, 0, 0), mk3(0, 0, 0), mk3(0, 0, 0)));
        send_item(particle(mk3(12800, 0, 0), mk3(100, 0, 0), mk3(0, 0, 0)));
        send_item(particle(mk3(12799, 0, 0), mk3(100, 0, 0), mk3(0, 0, 0)));
        send_item(particle(mk3(7680, 10240, 0), mk3(0, 0, 0), mk3(0, 0, 0)));
        send_item(particle(mk3(7680, 10239, 0), mk3(0, 0, 0), mk3(-5, 5, 0)));
        send_item(particle(mk3(8388607, 8388607, 8388607), mk3(8388607, 8388607, 8388607),
                           mk3(-8388608, -8388608, -8388608)));
        send_item(particle(mk3(-8388608, -8388608, -8388608),
                           mk3(-8388608, -8388608, -8388608), mk3(8388607, 8388607, 8388607)));
        send_item(hand_load(1, 1, mk3(8388607, -8388608, 0),
                            mk3(8388607, -8388608, 8388607)));
        send_item(hand_load(0, 1, mk3(8388600, -8388600, 10), mk3(8388607, -8388608, 8388607)));
        send_item(particle(mk3(8388607, -8388608, 0), mk3(8388607, -8388608, 8388607),
                           mk3(0, 0, 0)));
        send_item(particle(mk3(8388607, -8388608, 0), mk3(-1, 1, -1), mk3(-1, -1, -1)));
        drain();
        set_config(65535, 65535, 8388607);
        send_item(particle(mk3(8388607, -8388608, 0), mk3(8388607, -8388608, 8388607),
                           mk3(8388607, -8388608, 0)));
        send_item(particle(mk3(-8388608, 8388607, 0), mk3(8388607, 8388607, -8388608),
                           mk3(8388607, -8388608, 0)));
        set_config(0, 0, 0);
        send_item(hand_load(0, 1, mk3(0, 0, 0), mk3(100000, 100000, 100000)));
        send_item(particle(mk3(1279, 0, 0), mk3(77, -77, 0), mk3(5, 5, 5)));
        send_item(particle(mk3(1280, 0, 0), mk3(77, -77, 0), mk3(5, 5, 5)));
        set_config(65535, 0, 1279);
        send_item(particle(mk3(1279, 0, 0), mk3(77, -77, 0), mk3(5, 5, 5)));
        send_item(particle(mk3(1280, 0, 0), mk3(77, -77, 0), mk3(5, 5, 5)));
    endtask

    task automatic random_phase(int count);
        int             roll, span;
        bit             h;
        particle_item_t it;
        span = (radius_mirror < 1280) ? 1600 : int'(radius_mirror * 5 / 4);
        if (span > 4000000) span = 4000000;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 9);
            h = 1'($urandom);
            if (roll < 2) begin
                it = hand_load(h, $urandom_range(0, 3) != 0,
                               ($urandom_range(0, 3) == 0) ? any3() : small3(300000),
                               ($urandom_range(0, 3) == 0) ? any3() : small3(20000));
            end else if (roll < 9) begin
                it = particle(near3(hand_pos[h], span),
                              ($urandom_range(0, 4) == 0) ? any3() : small3(50000),
                              ($urandom_range(0, 4) == 0) ? any3() : near3(hand_pos[h], 100000));
            end else begin
                it = particle(any3(), any3(), any3());
            end
            if ($urandom_range(0, 49) == 0) tx_quiet = ~tx_quiet;
            if ($urandom_range(0, 49) == 0) rx_quiet = ~rx_quiet;
            send_item(it);
        end
        tx_quiet = 0;
        rx_quiet = 0;
    endtask

    task automatic test_config_sweep;
        set_config(3277, 1638, 12800);
        random_phase(200);
        set_config(65535, 65535, 1280);
        random_phase(120);
        set_config(0, 0, 0);
        random_phase(100);
        set_config(32768, 16384, 8388607);
        random_phase(120);
        set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(1280, 200000));
        random_phase(150);
    endtask

    task automatic test_backpressure;
        set_config(40000, 2000, 30000);
        tx_quiet = 1;
        rx_hold = 80;
        random_phase(60);
        drain();
        random_phase(40);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DAMPING;
        cfg_data <= '0;
        damping_mirror = DAMPING_RESET;
        rate_mirror = RETURN_RESET;
        radius_mirror = RADIUS_RESET;
        for (int h = 0; h < 2; h++) begin
            hand_on[h] = 0;
            hand_pos[h] = '0;
            hand_vel[h] = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        drain();
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
